>>> design/segmented_memory_access_unit_macros.svh
// Assertion helpers for the segmented memory access unit.
// Each macro samples on clock and is disabled while reset is high.
`ifndef SEGMENTED_MEMORY_ACCESS_UNIT_MACROS_SVH
`define SEGMENTED_MEMORY_ACCESS_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMAU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/smau_pkg.sv
package smau_pkg;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_INDEX_W = 4;
   localparam int FAULT_W     = 2;

   localparam logic [FAULT_W-1:0] FAULT_NONE   = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_NO_SEG = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_BOUNDS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_REDUCE,
      ST_ACCESS,
      ST_COLLECT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic accept;
      logic lookup;
      logic reduce;
      logic access;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic lookup_fault;
      logic last_byte;
      logic rsp_busy;
   } status_type;

endpackage

>>> design/segmented_memory_access_unit.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_tvalid/tready    tdata, tuser (read or write request)
// rsp_      out        rsp_tvalid/tready    tdata, tuser (read data, address, fault)
// csr_      in         csr_valid/csr_ready  csr_index, csr_data (segment entries)
//
// One request at a time: a faulting request skips the byte access, and for a good one the
// single-port byte memory moves one byte per cycle.
// The result sits in an output register, so the next request may start while it waits.
// Reset is synchronous, active high; it marks every segment entry invalid and clears
// the LAR, MAR and MBR latches. Byte memory contents are not reset.
module segmented_memory_access_unit #(
   parameter int NUM_SEGMENTS = 8,
   parameter int MEM_BYTES    = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   // lowest bit up: logical_address[31:0], byte_count[34:32], write_value[66:35], zero
   input  logic [smau_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // action (0 read, 1 write)
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // lowest bit up: read_data[31:0], physical_address[47:32]
   output logic [smau_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // fault
   output logic [smau_pkg::FAULT_W-1:0]        rsp_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [smau_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_data
);

   smau_pkg::cmd_type    cmd;
   smau_pkg::status_type status;

   assign csr_ready = 1'b1;

   smau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   smau_dp #(
      .NUM_SEGMENTS (NUM_SEGMENTS),
      .MEM_BYTES    (MEM_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> design/smau_ctrl.sv
module smau_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  smau_pkg::status_type status,
   output smau_pkg::cmd_type    cmd
);

   smau_pkg::state_type state_ff;
   smau_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smau_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = smau_pkg::ST_LOOKUP;
         end
         smau_pkg::ST_LOOKUP: begin
            state_in = status.lookup_fault ? smau_pkg::ST_REPLY : smau_pkg::ST_REDUCE;
         end
         smau_pkg::ST_REDUCE: begin
            state_in = smau_pkg::ST_ACCESS;
         end
         smau_pkg::ST_ACCESS: begin
            if (status.last_byte) state_in = smau_pkg::ST_COLLECT;
         end
         smau_pkg::ST_COLLECT: begin
            state_in = smau_pkg::ST_REPLY;
         end
         smau_pkg::ST_REPLY: begin
            // wait until the previous result has been taken
            if (!status.rsp_busy) state_in = smau_pkg::ST_IDLE;
         end
         default: begin
            state_in = smau_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         smau_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         smau_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         smau_pkg::ST_REDUCE: begin
            cmd.reduce = 1'b1;
         end
         smau_pkg::ST_ACCESS: begin
            cmd.access = 1'b1;
         end
         smau_pkg::ST_COLLECT: begin
            cmd = '0;
         end
         smau_pkg::ST_REPLY: begin
            cmd.load_rsp = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smau_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> design/smau_dp.sv
module smau_dp #(
   parameter int NUM_SEGMENTS = 8,
   parameter int MEM_BYTES    = 65536
) (
   input  logic                                clock,
   input  logic                                reset,
   input  smau_pkg::cmd_type                   cmd,
   output smau_pkg::status_type                status,
   input  logic                                csr_valid,
   input  logic [smau_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_data,
   input  logic [smau_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [smau_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [smau_pkg::FAULT_W-1:0]        rsp_tuser
);

   localparam int AW = $clog2(MEM_BYTES);

   // segment table
   logic [31:0] tbl_ff [NUM_SEGMENTS];
   logic [31:0] tbl_in [NUM_SEGMENTS];

   // request and latches
   logic [31:0] lar_ff, lar_in;
   logic [31:0] mar_ff, mar_in;
   logic [31:0] mbr_ff, mbr_in;
   logic        act_ff, act_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] wval_ff, wval_in;
   logic [smau_pkg::FAULT_W-1:0] fault_ff, fault_in;
   logic [15:0] phys_ff, phys_in;

   // byte walk
   logic [15:0]   p16_ff, p16_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [1:0]    rem_ff, rem_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [31:0]   acc_ff, acc_in;
   logic [7:0]    rd_byte_ff;
   logic [7:0]    mem [MEM_BYTES];
   logic          mem_we;
   logic [7:0]    wr_byte;
   logic [31:0]   wr_shift;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [15:0] rsp_phys_ff, rsp_phys_in;
   logic [smau_pkg::FAULT_W-1:0] rsp_fault_ff, rsp_fault_in;

   // translation
   logic [2:0]  req_cnt;
   logic [31:0] entry;
   logic        seg_ok;
   logic        exists;
   logic [16:0] phys17;
   logic [16:0] limit17;
   logic [17:0] need18;
   logic [smau_pkg::FAULT_W-1:0] lookup_fault;
   logic [22:0] red_x;
   logic [31:0] sext;
   logic        read_ok;

   // clamp the byte count into 1..4
   always_comb begin
      req_cnt = req_tdata[34:32];
      if (req_cnt == 3'd0) begin
         req_cnt = 3'd1;
      end else if (req_cnt > 3'd4) begin
         req_cnt = 3'd4;
      end
   end

   always_comb begin
      entry = '0;
      for (int i = 0; i < NUM_SEGMENTS; i++) begin
         if (lar_ff[31:16] == 16'(i)) entry = tbl_ff[i];
      end
      seg_ok  = lar_ff[31:16] < 16'(NUM_SEGMENTS);
      exists  = seg_ok && !entry[31];
      phys17  = {1'b0, entry[31:16]} + {1'b0, lar_ff[15:0]};
      limit17 = {1'b0, entry[31:16]} + {1'b0, entry[15:0]};
      need18  = {1'b0, phys17} + {15'b0, cnt_ff};
      if (!exists) begin
         lookup_fault = smau_pkg::FAULT_NO_SEG;
      end else if ({1'b0, limit17} < need18) begin
         lookup_fault = smau_pkg::FAULT_BOUNDS;
      end else begin
         lookup_fault = smau_pkg::FAULT_NONE;
      end
   end

   // fold the physical address into the memory range by restoring subtraction
   always_comb begin
      red_x = {7'b0, mar_ff[15:0]};
      for (int i = 6; i >= 0; i--) begin
         if (red_x >= (23'(MEM_BYTES) << i)) red_x = red_x - (23'(MEM_BYTES) << i);
      end
   end

   always_comb begin
      case (mar_ff[18:16])
         3'd1:    sext = {{24{acc_ff[7]}}, acc_ff[7:0]};
         3'd2:    sext = {{16{acc_ff[15]}}, acc_ff[15:0]};
         3'd3:    sext = {{8{acc_ff[23]}}, acc_ff[23:0]};
         default: sext = acc_ff;
      endcase
      read_ok = (fault_ff == smau_pkg::FAULT_NONE) && !act_ff;
   end

   assign wr_shift = mbr_ff >> {rem_ff, 3'b000};
   assign wr_byte  = wr_shift[7:0];
   assign mem_we   = cmd.access && act_ff;

   always_comb begin
      tbl_in       = tbl_ff;
      lar_in       = lar_ff;
      mar_in       = mar_ff;
      mbr_in       = mbr_ff;
      act_in       = act_ff;
      cnt_in       = cnt_ff;
      wval_in      = wval_ff;
      fault_in     = fault_ff;
      phys_in      = phys_ff;
      p16_in       = p16_ff;
      addr_in      = addr_ff;
      rem_in       = rem_ff;
      rd_pend_in   = cmd.access && !act_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_phys_in  = rsp_phys_ff;
      rsp_fault_in = rsp_fault_ff;

      for (int i = 0; i < NUM_SEGMENTS; i++) begin
         if (csr_valid && csr_index == smau_pkg::CSR_INDEX_W'(i)) tbl_in[i] = csr_data;
      end

      if (cmd.accept) begin
         lar_in  = req_tdata[31:0];
         act_in  = req_tuser;
         cnt_in  = req_cnt;
         wval_in = req_tdata[66:35];
         acc_in  = '0;
      end

      if (cmd.lookup) begin
         fault_in = lookup_fault;
         phys_in  = exists ? phys17[15:0] : 16'd0;
         if (lookup_fault == smau_pkg::FAULT_NONE) begin
            mar_in = {13'd0, cnt_ff, phys17[15:0]};
            if (act_ff) mbr_in = wval_ff;
         end
      end

      if (cmd.reduce) begin
         p16_in  = mar_ff[15:0];
         addr_in = AW'(red_x);
         rem_in  = 2'(mar_ff[18:16] - 3'd1);
      end

      if (cmd.access) begin
         p16_in = p16_ff + 16'd1;
         rem_in = rem_ff - 2'd1;
         if (p16_ff == 16'hFFFF || addr_ff == AW'(MEM_BYTES - 1)) begin
            addr_in = '0;
         end else begin
            addr_in = addr_ff + AW'(1);
         end
      end

      // shift in the byte that the memory read in the previous cycle
      if (rd_pend_ff) acc_in = {acc_ff[23:0], rd_byte_ff};

      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_fault_in = fault_ff;
         rsp_phys_in  = phys_ff;
         rsp_data_in  = read_ok ? sext : 32'd0;
         if (read_ok) mbr_in = sext;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[addr_ff] <= wr_byte;
      rd_byte_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SEGMENTS; i++) tbl_ff[i] <= '1;
         lar_ff       <= '0;
         mar_ff       <= '0;
         mbr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tbl_ff       <= tbl_in;
         lar_ff       <= lar_in;
         mar_ff       <= mar_in;
         mbr_ff       <= mbr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      cnt_ff       <= cnt_in;
      wval_ff      <= wval_in;
      fault_ff     <= fault_in;
      phys_ff      <= phys_in;
      p16_ff       <= p16_in;
      addr_ff      <= addr_in;
      rem_ff       <= rem_in;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_phys_ff  <= rsp_phys_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign status.lookup_fault = lookup_fault != smau_pkg::FAULT_NONE;
   assign status.last_byte    = rem_ff == 2'd0;
   assign status.rsp_busy     = rsp_valid_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_phys_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_fault_ff;

endmodule

>>> design/smau_checker.sv
`include "segmented_memory_access_unit_macros.svh"

module smau_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [smau_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input logic [smau_pkg::FAULT_W-1:0]        rsp_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready
);

   `SMAU_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")
   `SMAU_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "second request taken while one is in flight")
   `SMAU_ASSERT_SAME(a_fault_code, rsp_tvalid, rsp_tuser != 2'd3, "undefined fault code")
   `SMAU_ASSERT_SAME(a_no_seg_zero, rsp_tvalid && rsp_tuser == smau_pkg::FAULT_NO_SEG, rsp_tdata == '0, "missing segment result not zero")
   `SMAU_ASSERT_SAME(a_bounds_zero, rsp_tvalid && rsp_tuser == smau_pkg::FAULT_BOUNDS, rsp_tdata[31:0] == 32'd0, "bounds fault carries read data")

endmodule

bind segmented_memory_access_unit smau_checker u_smau_checker (.*);
